/* src/amwu_pkg.sv */
`default_nettype none
package amwu_pkg;

    localparam int DEF_NUM_WEIGHTS = 4096;
    localparam int DEF_FRAC_BITS   = 24;

    localparam int IDX_W     = 12;
    localparam int VAL_W     = 32;
    localparam int LR_W      = 25;
    localparam int DECAY_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 25;

    localparam logic [LR_W-1:0]    LR_ONE      = 25'd16777216;
    localparam logic [LR_W-1:0]    LR_RESET    = 25'd16777;
    localparam logic [DECAY_W-1:0] DECAY_ONE   = 17'd65536;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 17'd58982;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY         = 2'd1;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // step magnitude is clamped to 2^40 weight LSBs
    localparam int          Q_BITS = 41;
    localparam logic [40:0] Q_MAX  = 41'h100_0000_0000;

    localparam int FIFO_DEPTH = 4;

    localparam logic signed [51:0] S32_MAX_W = 52'sd2147483647;
    localparam logic signed [51:0] S32_MIN_W = -52'sd2147483648;

    typedef struct packed {
        logic                    valid;
        logic                    load;
        logic                    inr;
        logic                    m_neg;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
    } item_t;

    typedef struct packed {
        logic [LR_W-1:0]    lr;
        logic [DECAY_W-1:0] decay;
    } cfg_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
        logic signed [51:0] r;
        if (x > S32_MAX_W) begin
            r = S32_MAX_W;
        end else if (x < S32_MIN_W) begin
            r = S32_MIN_W;
        end else begin
            r = x;
        end
        return r[31:0];
    endfunction

    // divide by 2^16, rounding half away from zero
    function automatic logic signed [51:0] round16(input logic signed [51:0] x);
        logic [51:0] mag;
        logic [51:0] r;
        mag = x[51] ? 52'(-x) : 52'(x);
        r   = (mag + 52'd32768) >> 16;
        return x[51] ? -$signed(r) : $signed(r);
    endfunction

endpackage
`default_nettype wire

/* src/amwu_front.sv */
`default_nettype none
module amwu_front
    import amwu_pkg::*;
#(
    parameter int NUM_WEIGHTS = DEF_NUM_WEIGHTS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    command,
    input  wire logic [IDX_W-1:0]        entry_index,
    input  wire logic signed [VAL_W-1:0] value,
    input  wire ctl_t                    ctl,
    output item_t                        head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    item_t            fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push;
    item_t            cls;

    assign in_ready = (count_reg != (PTR_W+1)'(FIFO_DEPTH)) && !ctl.clearing;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        cls       = '0;
        cls.valid = 1'b1;
        cls.load  = (command == CMD_LOAD);
        cls.inr   = (32'(entry_index) < 32'(NUM_WEIGHTS));
        cls.idx   = entry_index;
        cls.val   = value;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = ctl.pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(ctl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= cls;
        end
    end

    always_comb
    begin
        head       = fifo_mem[rd_ptr_reg];
        head.valid = (count_reg != '0);
    end

endmodule
`default_nettype wire

/* src/amwu_sqrt.sv */
`default_nettype none
module amwu_sqrt #(
    parameter int IN_W = 55
) (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [IN_W-1:0]           x,
    output logic [(IN_W+1)/2-1:0]          root
);

    localparam int RT_W = (IN_W + 1) / 2;
    localparam int TW   = 2 * RT_W + 1;

    logic [TW-1:0] rem_reg  [RT_W-1];
    logic [TW-1:0] root_reg [RT_W];

    // one result bit per stage, most significant first
    for (genvar s = 0; s < RT_W; s++)
    begin : g_stage
        localparam int B = RT_W - 1 - s;
        logic [TW-1:0] rem_in;
        logic [TW-1:0] root_in;
        logic [TW-1:0] trial;
        logic          take;

        if (s == 0)
        begin : g_first
            assign rem_in  = TW'(x);
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        assign trial = (root_in << (B + 1)) | (TW'(1) << (2 * B));
        assign take  = (rem_in >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s] <= take ? (root_in | (TW'(1) << B)) : root_in;
            end
        end

        if (s < RT_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? rem_in - trial : rem_in;
                end
            end
        end
    end

    assign root = root_reg[RT_W-1][RT_W-1:0];

endmodule
`default_nettype wire

/* src/amwu_div.sv */
`default_nettype none
module amwu_div #(
    parameter int NW = 58,
    parameter int DW = 29,
    parameter int QB = 41
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] n,
    input  wire logic [DW-1:0] dv,
    output logic [QB-1:0]      q,
    output logic               ovf
);

    localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

    logic [CW-1:0] rem_reg [QB];
    logic [DW-1:0] dv_reg  [QB];
    logic [QB-1:0] q_reg   [QB];
    logic          ovf_reg [QB+1];

    // quotient too wide for the result: flag it and clamp later
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= CW'(n);
            dv_reg[0]  <= dv;
            ovf_reg[0] <= (CW'(n) >= (CW'(dv) << QB));
        end
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        localparam int B = QB - 1 - s;
        logic [CW-1:0] trial;
        logic [QB-1:0] q_in;
        logic          take;

        if (s == 0)
        begin : g_first
            assign q_in = '0;
        end
        else
        begin : g_next
            assign q_in = q_reg[s-1];
        end

        assign trial = CW'(dv_reg[s]) << B;
        assign take  = (rem_reg[s] >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[s]     <= take ? (q_in | (QB'(1) << B)) : q_in;
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end

        if (s < QB - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s+1] <= take ? rem_reg[s] - trial : rem_reg[s];
                    dv_reg[s+1]  <= dv_reg[s];
                end
            end
        end
    end

    assign q   = q_reg[QB-1];
    assign ovf = ovf_reg[QB];

endmodule
`default_nettype wire

/* src/amwu_back.sv */
`default_nettype none
module amwu_back
    import amwu_pkg::*;
#(
    parameter int NUM_WEIGHTS = DEF_NUM_WEIGHTS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire item_t             head,
    output ctl_t                   ctl,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [IDX_W-1:0]       entry_index_out,
    output logic signed [VAL_W-1:0] new_weight
);

    localparam int AW     = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam int SQ_IN_W = 31 + FRAC_BITS;
    localparam int RT_W   = (SQ_IN_W + 1) / 2;
    localparam int DIV_SH = (FRAC_BITS <= 24) ? 24 - FRAC_BITS : 0;
    localparam int NUM_SH = (FRAC_BITS > 24) ? FRAC_BITS - 24 : 0;
    localparam int DV_W   = RT_W + 1 + DIV_SH;
    localparam int NM_W   = LR_W + 32 + NUM_SH;
    localparam int N_W    = ((NM_W > DV_W) ? NM_W : DV_W) + 1;
    localparam int CL_N   = RT_W + Q_BITS + 1;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W+AW-1:0] ext;
        ext = (IDX_W+AW)'(idx);
        return ext[AW-1:0];
    endfunction

    logic signed [31:0] m_mem [NUM_WEIGHTS];
    logic signed [31:0] v_mem [NUM_WEIGHTS];
    logic signed [31:0] w_mem [NUM_WEIGHTS];

    logic          adv;
    logic          hazard;
    logic          pop;
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;
    item_t         st1_in;

    logic [DECAY_W-1:0]  dec, omd;
    logic [LR_W-1:0]     lr;
    logic signed [17:0]  d_s, omd_s;

    item_t              st1_reg, st2_reg, st3_reg, st4_reg, st5_reg;
    logic signed [31:0] m_rd_reg, v_rd_reg, v2_reg;
    logic [30:0]        gsq2_reg, gsq3_reg;
    logic signed [49:0] pm2_reg, pg2_reg, pv3_reg, pv4_reg;
    logic signed [31:0] m3_reg, m4_reg, m5_reg, v5_reg;
    logic [47:0]        qv4_reg;

    item_t              cl_reg  [CL_N];
    logic [NM_W-1:0]    num_reg [RT_W];

    logic signed [31:0] w_rd_reg;
    logic               lw_valid_reg;
    logic [IDX_W-1:0]   lw_idx_reg;
    logic signed [31:0] lw_val_reg;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic signed [31:0] out_w_reg;

    assign dec   = (cfg.decay > DECAY_ONE) ? DECAY_ONE : cfg.decay;
    assign omd   = DECAY_ONE - dec;
    assign lr    = (cfg.lr > LR_ONE) ? LR_ONE : cfg.lr;
    assign d_s   = {1'b0, dec};
    assign omd_s = {1'b0, omd};

    assign adv = !out_valid_reg || out_ready;

    // hold an update while an older beat on the same entry has not written its moments
    always_comb
    begin
        hazard = 1'b0;
        if (head.valid && head.inr && (head.load == CMD_UPDATE))
        begin
            hazard = (st1_reg.valid && st1_reg.inr && st1_reg.idx == head.idx)
                  || (st2_reg.valid && st2_reg.inr && st2_reg.idx == head.idx)
                  || (st3_reg.valid && st3_reg.inr && st3_reg.idx == head.idx)
                  || (st4_reg.valid && st4_reg.inr && st4_reg.idx == head.idx);
        end
    end

    assign pop          = adv && head.valid && !hazard && !clearing_reg;
    assign ctl.pop      = pop;
    assign ctl.clearing = clearing_reg;

    always_comb
    begin
        st1_in       = head;
        st1_in.valid = pop;
    end

    // sweep the moment stores to their reset values after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(NUM_WEIGHTS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // stage 1: gradient square and first products
    logic [31:0]        gmag;
    logic [63:0]        gsq_full, gsq_shr;
    logic [30:0]        gsq_c;
    logic signed [49:0] pm_c, pg_c;

    always_comb
    begin
        gmag     = st1_reg.val[31] ? (~st1_reg.val + 32'd1) : st1_reg.val;
        gsq_full = 64'(gmag) * 64'(gmag);
        gsq_shr  = gsq_full >> FRAC_BITS;
        gsq_c    = (gsq_shr > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : gsq_shr[30:0];
        pm_c     = d_s * m_rd_reg;
        pg_c     = omd_s * st1_reg.val;
    end

    // stage 2: new first moment
    logic signed [51:0] msum;
    logic signed [31:0] m_new_c;
    logic signed [49:0] pv_c;

    always_comb
    begin
        msum    = 52'(pm2_reg) + 52'(pg2_reg);
        m_new_c = sat32(round16(msum));
        pv_c    = d_s * v2_reg;
    end

    // stage 3
    logic [47:0] qv_c;
    assign qv_c = 48'(omd) * 48'(gsq3_reg);

    // stage 4: new second moment, write back both moments (a load clears only the first)
    logic signed [51:0] vsum;
    logic signed [31:0] v_sat, v_new_c;
    logic               m_we, v_we;
    logic [AW-1:0]      mv_addr;
    logic signed [31:0] m_wdata, v_wdata;

    always_comb
    begin
        vsum    = 52'(pv4_reg) + $signed({4'b0, qv4_reg});
        v_sat   = sat32(round16(vsum));
        v_new_c = v_sat[31] ? 32'sd0 : v_sat;
        if (clearing_reg)
        begin
            m_we    = 1'b1;
            v_we    = 1'b1;
            mv_addr = clr_cnt_reg;
            m_wdata = '0;
            v_wdata = 32'(1) << FRAC_BITS;
        end
        else
        begin
            m_we    = adv && st4_reg.valid && st4_reg.inr;
            v_we    = m_we && (st4_reg.load == CMD_UPDATE);
            mv_addr = to_addr(st4_reg.idx);
            m_wdata = (st4_reg.load == CMD_LOAD) ? 32'sd0 : m4_reg;
            v_wdata = v_new_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            m_mem[mv_addr] <= m_wdata;
        end
        if (v_we)
        begin
            v_mem[mv_addr] <= v_wdata;
        end
        if (adv)
        begin
            m_rd_reg <= m_mem[to_addr(head.idx)];
            v_rd_reg <= v_mem[to_addr(head.idx)];
        end
    end

    // stage 5: root input and step numerator
    logic [SQ_IN_W-1:0] sq_x;
    logic [31:0]        mmag;
    logic [NM_W-1:0]    num_c;
    item_t              cl_in;

    always_comb
    begin
        sq_x        = {v5_reg[30:0], {FRAC_BITS{1'b0}}};
        mmag        = m5_reg[31] ? (~m5_reg + 32'd1) : m5_reg;
        num_c       = NM_W'(NM_W'(lr) * NM_W'(mmag)) << NUM_SH;
        cl_in       = st5_reg;
        cl_in.m_neg = m5_reg[31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_reg <= '0;
            st2_reg <= '0;
            st3_reg <= '0;
            st4_reg <= '0;
            st5_reg <= '0;
            for (int i = 0; i < CL_N; i++)
            begin
                cl_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            st1_reg       <= st1_in;
            st2_reg       <= st1_reg;
            st3_reg       <= st2_reg;
            st4_reg       <= st3_reg;
            st5_reg       <= st4_reg;
            cl_reg[0]     <= cl_in;
            for (int i = 1; i < CL_N; i++)
            begin
                cl_reg[i] <= cl_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gsq2_reg <= gsq_c;
            pm2_reg  <= pm_c;
            pg2_reg  <= pg_c;
            v2_reg   <= v_rd_reg;
            m3_reg   <= m_new_c;
            pv3_reg  <= pv_c;
            gsq3_reg <= gsq2_reg;
            m4_reg   <= m3_reg;
            pv4_reg  <= pv3_reg;
            qv4_reg  <= qv_c;
            m5_reg   <= m4_reg;
            v5_reg   <= v_new_c;
            num_reg[0] <= num_c;
            for (int i = 1; i < RT_W; i++)
            begin
                num_reg[i] <= num_reg[i-1];
            end
        end
    end

    logic [RT_W-1:0] root;

    amwu_sqrt #(
        .IN_W (SQ_IN_W)
    ) u_sqrt (
        .clk  (clk),
        .en   (adv),
        .x    (sq_x),
        .root (root)
    );

    logic [DV_W-1:0]   dv_c;
    logic [N_W-1:0]    n_c;
    logic [Q_BITS-1:0] q_raw;
    logic              q_ovf;

    always_comb
    begin
        dv_c = DV_W'(DV_W'(root) + DV_W'(1)) << DIV_SH;
        n_c  = N_W'(num_reg[RT_W-1]) + N_W'(dv_c >> 1);
    end

    amwu_div #(
        .NW (N_W),
        .DW (DV_W),
        .QB (Q_BITS)
    ) u_div (
        .clk (clk),
        .en  (adv),
        .n   (n_c),
        .dv  (dv_c),
        .q   (q_raw),
        .ovf (q_ovf)
    );

    // final stage: apply the step to the weight
    item_t              fin;
    logic [Q_BITS-1:0]  q_cl;
    logic signed [31:0] w_old, w_new;
    logic signed [51:0] w_sum;
    logic               w_we;

    always_comb
    begin
        fin   = cl_reg[CL_N-1];
        q_cl  = (q_ovf || q_raw > Q_MAX) ? Q_MAX : q_raw;
        // forward the weight written one beat earlier
        w_old = (lw_valid_reg && lw_idx_reg == fin.idx) ? lw_val_reg : w_rd_reg;
        w_sum = fin.m_neg ? 52'(w_old) + $signed({11'b0, q_cl})
                          : 52'(w_old) - $signed({11'b0, q_cl});
        w_new = (fin.load == CMD_LOAD) ? fin.val : sat32(w_sum);
        w_we  = adv && fin.valid && fin.inr;
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[to_addr(fin.idx)] <= w_new;
        end
        if (adv)
        begin
            w_rd_reg <= w_mem[to_addr(cl_reg[CL_N-2].idx)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (w_we)
            begin
                lw_valid_reg <= 1'b1;
            end
            if (adv)
            begin
                out_valid_reg <= fin.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            lw_idx_reg <= fin.idx;
            lw_val_reg <= w_new;
        end
        if (adv)
        begin
            out_idx_reg <= fin.idx;
            out_w_reg   <= fin.inr ? w_new : 32'sd0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign entry_index_out = out_idx_reg;
    assign new_weight      = out_w_reg;

endmodule
`default_nettype wire

/* src/adaptive_moment_weight_update.sv */
`default_nettype none
// Adam-style weight update engine without bias correction. A load beat writes a weight,
// clears its first moment and returns it; an update beat folds the gradient into both
// moment averages and returns w - lr*m/(sqrt(v)+1 LSB), saturated. One beat is taken
// each cycle unless the output is stalled; an update is also held at the queue head
// while an earlier beat on the same entry is still in the four moment stages, the span
// between the moment store read and its write-back. A beat then passes the bit-per-stage
// square root, whose root width is (31 + FRAC_BITS + 1) / 2, and the 41-stage restoring
// divider before its step is applied. After reset the moment stores are swept to zero
// and 1.0, and no beat is accepted during the sweep; configuration writes are taken at
// any time.
module adaptive_moment_weight_update
    import amwu_pkg::*;
#(
    parameter int NUM_WEIGHTS = DEF_NUM_WEIGHTS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DAT_W-1:0]    cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    command,
    input  wire logic [IDX_W-1:0]        entry_index,
    input  wire logic signed [VAL_W-1:0] value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [IDX_W-1:0]             entry_index_out,
    output logic signed [VAL_W-1:0]      new_weight
);

    logic [LR_W-1:0]    lr_reg;
    logic [DECAY_W-1:0] decay_reg;
    cfg_t               cfg;
    ctl_t               ctl;
    item_t              head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg    <= LR_RESET;
            decay_reg <= DECAY_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_LEARNING_RATE)
            begin
                lr_reg <= cfg_data[LR_W-1:0];
            end
            else if (cfg_index == REG_DECAY)
            begin
                decay_reg <= cfg_data[DECAY_W-1:0];
            end
        end
    end

    assign cfg.lr    = lr_reg;
    assign cfg.decay = decay_reg;

    amwu_front #(
        .NUM_WEIGHTS (NUM_WEIGHTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .entry_index (entry_index),
        .value       (value),
        .ctl         (ctl),
        .head        (head)
    );

    amwu_back #(
        .NUM_WEIGHTS (NUM_WEIGHTS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .head            (head),
        .ctl             (ctl),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .entry_index_out (entry_index_out),
        .new_weight      (new_weight)
    );

`ifndef ASSERT_OFF
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clearing |-> !in_ready)
        else $error("beat accepted during store sweep");

    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> (head.valid && !ctl.clearing))
        else $error("queue popped with no beat at its head");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (32'(entry_index_out) >= 32'(NUM_WEIGHTS))) |-> (new_weight == '0))
        else $error("out-of-range entry returned a non-zero weight");
`endif

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import amwu_pkg::*;

    localparam int LATENCY   = 76;
    localparam int CYCLE_CAP = 600000;
    localparam int N_PHASES  = 8;
    localparam int PHASE_LEN = 200;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic             typed;
        logic [VAL_W-1:0] w;
    } dir_row_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] w;
    } weight_beat_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DAT_W-1:0]    cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    command;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] value;
    logic                    out_valid;
    logic                    out_ready;
    logic [IDX_W-1:0]        entry_index_out;
    logic signed [VAL_W-1:0] new_weight;

    adaptive_moment_weight_update i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .entry_index     (entry_index),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .entry_index_out (entry_index_out),
        .new_weight      (new_weight)
    );

    // model state
    int              wt_mem    [DEF_NUM_WEIGHTS];
    int              mom_mem   [DEF_NUM_WEIGHTS];
    int              sqavg_mem [DEF_NUM_WEIGHTS];
    logic [LR_W-1:0]    lr_reg;
    logic [DECAY_W-1:0] decay_reg;

    weight_beat_t weight_due[$];
    logic         typed_pending[$];
    logic [VAL_W-1:0] typed_w[$];
    bit           loaded [DEF_NUM_WEIGHTS];
    int           errors;
    int           results_seen;
    int           cycles;
    int           idle_pct;
    int           stall_pct;

    dir_row_t dir_rows [0:13] = '{
        '{CMD_LOAD,   12'd0,    32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{CMD_LOAD,   12'd4095, 32'h8000_0000, 1'b1, 32'h8000_0000},
        '{CMD_LOAD,   12'd1,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{CMD_LOAD,   12'd2,    32'h00FF_FFFF, 1'b1, 32'h00FF_FFFF},
        '{CMD_UPDATE, 12'd1,    32'h0000_0000, 1'b0, 32'h0},
        '{CMD_UPDATE, 12'd0,    32'h7FFF_FFFF, 1'b0, 32'h0},
        '{CMD_UPDATE, 12'd4095, 32'h8000_0000, 1'b0, 32'h0},
        '{CMD_UPDATE, 12'd2,    32'h0000_0001, 1'b0, 32'h0},
        '{CMD_UPDATE, 12'd2,    32'hFFFF_FFFF, 1'b0, 32'h0},
        '{CMD_UPDATE, 12'd2,    32'h0100_0000, 1'b0, 32'h0},
        '{CMD_LOAD,   12'd2,    32'h0100_0000, 1'b1, 32'h0100_0000},
        '{CMD_UPDATE, 12'd2,    32'h0100_0000, 1'b0, 32'h0},
        '{CMD_LOAD,   12'd3,    32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{CMD_UPDATE, 12'd3,    32'h0000_0000, 1'b0, 32'h0}
    };

    function automatic longint clamp_s32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // halve 16 times, half away from zero
    function automatic longint round_q16(input longint x);
        longint unsigned mag;
        longint r;
        mag = (x < 0) ? longint'(-x) : longint'(x);
        r = longint'((mag + 64'd32768) >> 16);
        return (x < 0) ? -r : r;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] next_weight(input logic cmd, input logic [IDX_W-1:0] idx,
                                                     input logic [VAL_W-1:0] raw);
        longint val, d, omd, gsq, m, v, w;
        longint unsigned lr_e, gmag, gsq_u, den, num, q, mmag;
        val = longint'($signed(raw));
        if (cmd == CMD_LOAD) begin
            wt_mem[idx]  = int'(val);
            mom_mem[idx] = 0;
            return raw;
        end
        d    = (decay_reg > DECAY_ONE) ? 64'sd65536 : longint'(decay_reg);
        omd  = 64'sd65536 - d;
        lr_e = (lr_reg > LR_ONE) ? 64'd16777216 : longint'(lr_reg);
        gmag = (val < 0) ? longint'(-val) : longint'(val);
        gsq_u = (gmag * gmag) >> DEF_FRAC_BITS;
        gsq = (gsq_u > 64'd2147483647) ? 64'sd2147483647 : longint'(gsq_u);
        m = clamp_s32(round_q16(d * longint'(mom_mem[idx]) + omd * val));
        v = clamp_s32(round_q16(d * longint'(sqavg_mem[idx]) + omd * gsq));
        if (v < 0) v = 0;
        mom_mem[idx]   = int'(m);
        sqavg_mem[idx] = int'(v);
        den  = root_floor(longint'(v) << DEF_FRAC_BITS) + 64'd1;
        mmag = (m < 0) ? longint'(-m) : longint'(m);
        num  = lr_e * mmag;
        q = (num + (den >> 1)) / den;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        w = longint'(wt_mem[idx]);
        w = (m < 0) ? w + longint'(q) : w - longint'(q);
        w = clamp_s32(w);
        wt_mem[idx] = int'(w);
        return w[31:0];
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     weight_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // predict on accepted inputs, compare accepted results
    always @(posedge clk)
    begin
        weight_beat_t e;
        logic         t;
        logic [VAL_W-1:0] tw;
        if (rst_n && in_valid && in_ready)
        begin
            e.idx = entry_index;
            e.w   = next_weight(command, entry_index, value);
            if (typed_pending.size() != 0)
            begin
                t  = typed_pending.pop_front();
                tw = typed_w.pop_front();
                if (t) e.w = tw;
            end
            weight_due.push_back(e);
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (weight_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result beat: idx %0d weight %h",
                             entry_index_out, new_weight);
            end
            else
            begin
                e = weight_due.pop_front();
                if (e.idx !== entry_index_out || e.w !== new_weight)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected idx %0d weight %h, got idx %0d weight %h",
                                 e.idx, e.w, entry_index_out, new_weight);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_LEARNING_RATE) lr_reg = data;
        else if (idx == REG_DECAY) decay_reg = data[DECAY_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input logic typed,
                             input logic [VAL_W-1:0] w);
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        typed_pending.push_back(typed);
        typed_w.push_back(w);
        in_valid    <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        value       <= val;
        if (cmd == CMD_LOAD) loaded[idx] = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // called at a falling edge, right after the last acceptance
    task automatic drain();
        in_valid <= 1'b0;
        while (weight_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 33554432)) - 32'sd16777216);
            2: return 32'($signed($urandom_range(0, 2048)) - 32'sd1024);
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 536870912)) - 32'sd268435456);
        endcase
    endfunction

    initial
    begin
        logic             cmd;
        logic [IDX_W-1:0] idx;
        errors = 0;
        results_seen = 0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        command = CMD_LOAD;
        entry_index = '0;
        value = '0;
        lr_reg = LR_RESET;
        decay_reg = DECAY_RESET;
        for (int i = 0; i < DEF_NUM_WEIGHTS; i++)
        begin
            wt_mem[i] = 0;
            mom_mem[i] = 0;
            sqavg_mem[i] = 1 << DEF_FRAC_BITS;
            loaded[i] = 1'b0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed rows at the reset settings
        for (int r = 0; r < $size(dir_rows); r++)
            send_beat(dir_rows[r].cmd, dir_rows[r].idx, dir_rows[r].val, dir_rows[r].typed,
                      dir_rows[r].w);
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: begin write_reg(REG_LEARNING_RATE, LR_ONE); write_reg(REG_DECAY, 25'd0); end
                1: begin write_reg(REG_LEARNING_RATE, 25'd0); write_reg(REG_DECAY, 25'(DECAY_ONE)); end
                2: begin
                    write_reg(REG_LEARNING_RATE, 25'h1FF_FFFF);
                    write_reg(REG_DECAY, 25'h1_FFFF);
                    // unused indices must be ignored
                    write_reg(2'd2, 25'h155_5555);
                    write_reg(2'd3, 25'h0AA_AAAA);
                end
                3: begin write_reg(REG_LEARNING_RATE, LR_RESET); write_reg(REG_DECAY, 25'(DECAY_RESET)); end
                default: begin
                    write_reg(REG_LEARNING_RATE, 25'($urandom_range(0, 25'h1FF_FFFF)));
                    write_reg(REG_DECAY, 25'($urandom_range(0, 17'h1_FFFF)));
                end
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            @(negedge clk);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                // hot entries give back-to-back hits on the same weight
                idx = ($urandom_range(0, 99) < 60) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom);
                cmd = ($urandom_range(0, 99) < 20) ? CMD_LOAD : CMD_UPDATE;
                if (!loaded[idx]) cmd = CMD_LOAD;
                send_beat(cmd, idx, pick_value(), 1'b0, '0);
            end
            drain();
        end

        if (weight_due.size() != 0) errors++;
        $display("Covered %0d result beats over %0d settings phases with sender and receiver idling.",
                 results_seen, N_PHASES + 1);
        $display("Mismatches: %0d", errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
